// ----- hw/rtl/mac_learning_forwarding_table_assert.svh -----
// Assertion macros for the MAC learning table
`ifndef MAC_LEARNING_FORWARDING_TABLE_ASSERT_SVH
`define MAC_LEARNING_FORWARDING_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define MLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define MLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mlt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and codes of the MAC learning forwarding table.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam logic [2:0] OP_LEARN  = 3'd0;
    localparam logic [2:0] OP_STATIC = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_CHADDR = 3'd3;
    localparam logic [2:0] OP_DELPRT = 3'd4;
    localparam logic [2:0] OP_DELDEV = 3'd5;
    localparam logic [2:0] OP_SWEEP  = 3'd6;
    localparam logic [2:0] OP_TICK   = 3'd7;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [1:0] MODE_BOTH = 2'd2;

    localparam logic [2:0] REG_MAX_ENTRIES  = 3'd0;
    localparam logic [2:0] REG_AGEING_TICKS = 3'd1;

    // One slot's info word: valid, local, port, device
    typedef struct packed {
        logic       valid;
        logic       local_f;
        logic [5:0] port;
        logic [3:0] dev;
    } t_info;

    // One slot as read from the table memories
    typedef struct packed {
        logic [47:0] mac;
        t_info       info;
        logic [31:0] expiry;
    } t_slot;

endpackage

// ----- hw/rtl/mlt_mem.sv -----
// ----------------------------------------------------------------------------
// mlt_mem
// Slot storage: MAC, info and expiry memories with registered read, plus
// valid bits in flops that reset clears.
// ----------------------------------------------------------------------------
module mlt_mem #(
    parameter int TABLE_ENTRIES = 256,
    parameter int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [AW-1:0]   i_raddr,
    output mlt_pkg::t_slot  o_rdata,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  mlt_pkg::t_slot  i_wdata
);
    logic [47:0] r_mac [TABLE_ENTRIES];
    logic [10:0] r_inf [TABLE_ENTRIES];
    logic [31:0] r_exp [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [47:0] r_rmac;
    logic [10:0] r_rinf;
    logic [31:0] r_rexp;
    logic        r_rval;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mac[i_waddr] <= i_wdata.mac;
            r_inf[i_waddr] <= i_wdata.info[10:0];
            r_exp[i_waddr] <= i_wdata.expiry;
        end
        r_rmac <= r_mac[i_raddr];
        r_rinf <= r_inf[i_raddr];
        r_rexp <= r_exp[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rval  <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= i_wdata.info.valid;
            r_rval <= r_valid[i_raddr];
        end
    end

    assign o_rdata = {r_rmac, r_rval, r_rinf, r_rexp};
endmodule

// ----- hw/rtl/mlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlt_ctrl
// Operation sequencer: scans the slots one a cycle, then applies the
// single-slot write of learn, lookup and insert operations.
// ----------------------------------------------------------------------------
`include "mac_learning_forwarding_table_assert.svh"
module mlt_ctrl #(
    parameter int TABLE_ENTRIES = 256,
    parameter int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [2:0]      i_opcode,
    input  logic [47:0]     i_mac_address,
    input  logic [3:0]      i_phys_device,
    input  logic [5:0]      i_port_id,
    input  logic            i_all_ports,
    input  logic [1:0]      i_local_mode,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_status,
    output logic [5:0]      o_dest_port,
    output logic [8:0]      o_removed_count,
    output logic [8:0]      o_live_count,
    input  logic [8:0]      i_max_entries,
    input  logic [15:0]     i_ageing_ticks,
    output logic [AW-1:0]   o_raddr,
    input  mlt_pkg::t_slot  i_rdata,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output mlt_pkg::t_slot  o_wdata
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam int CW = AW + 1;

    t_state      r_state, n_state;
    logic [2:0]  r_op;
    logic [47:0] r_mac;
    logic [3:0]  r_dev;
    logic [5:0]  r_port;
    logic        r_all;
    logic [1:0]  r_mode;
    logic [CW-1:0] r_idx;      // address issued this cycle
    logic        r_rd_vld;     // read data belongs to r_idx - 1
    logic [AW-1:0] r_rd_addr;
    logic [31:0] r_time;
    logic [CW-1:0] r_count;
    logic [8:0]  r_removed;
    logic        r_hit, r_free, r_cl;
    logic [AW-1:0] r_hit_addr, r_free_addr;
    mlt_pkg::t_info r_hit_info;
    logic        r_ov;
    logic [2:0]  r_status;
    logic [5:0]  r_dest;

    mlt_pkg::t_slot s;
    logic key_m, del_m, cl_m;
    logic [31:0] stamp, age;
    logic bad_addr, limit_hit;

    assign s     = i_rdata;
    assign stamp = r_time + {16'd0, i_ageing_ticks};
    assign age   = r_time - s.expiry;
    assign key_m = s.info.valid && s.mac == r_mac && s.info.dev == r_dev;
    assign cl_m  = s.info.valid && s.info.local_f && s.info.port == r_port;
    assign bad_addr = (r_mac == 48'd0) || r_mac[40];

    // insert operations drop the old entry during the scan; the freed slot
    // then competes for the lowest free slot
    always_comb begin
        case (r_op)
            mlt_pkg::OP_STATIC: del_m = !bad_addr && key_m;
            mlt_pkg::OP_CHADDR: del_m = (cl_m && !r_cl) || (!bad_addr && key_m);
            mlt_pkg::OP_DELPRT: del_m = s.info.valid && (r_all || s.info.port == r_port);
            mlt_pkg::OP_DELDEV: del_m = s.info.valid && s.info.dev == r_dev &&
                ((r_mode == mlt_pkg::MODE_BOTH) ||
                 (r_mode[1] == 1'b0 && s.info.local_f == r_mode[0]));
            mlt_pkg::OP_SWEEP:  del_m = s.info.valid && !s.info.local_f && !age[31];
            default:            del_m = 1'b0;
        endcase
    end

    assign limit_hit = (i_max_entries != 9'd0) && (32'(i_max_entries) <= 32'(r_count));

    assign o_in_stall = (r_state != S_IDLE);
    assign o_raddr    = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = (i_opcode == mlt_pkg::OP_TICK) ? S_OUT : S_SCAN;
            S_SCAN: if (r_rd_vld && r_rd_addr == AW'(TABLE_ENTRIES-1)) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // scan-time writes (deletes, insert removals) and finish-time write
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_rd_addr;
        o_wdata = s;
        o_wdata.info.valid = 1'b0;
        if (r_state == S_SCAN && r_rd_vld && del_m) begin
            o_we = 1'b1;
        end else if (r_state == S_FIN) begin
            o_wdata.mac    = r_mac;
            o_wdata.expiry = stamp;
            o_wdata.info   = '{valid: 1'b1, local_f: 1'b0, port: r_port, dev: r_dev};
            unique case (r_op) inside
                mlt_pkg::OP_LEARN: begin
                    if (r_hit) begin
                        o_we = 1'b1; o_waddr = r_hit_addr;
                        o_wdata.info.local_f = r_hit_info.local_f;
                    end else if (r_free && !limit_hit) begin
                        o_we = 1'b1; o_waddr = r_free_addr;
                    end
                end
                mlt_pkg::OP_LOOKUP: begin
                    o_wdata.info = r_hit_info;
                    if (r_hit && !r_hit_info.local_f) begin
                        o_we = 1'b1; o_waddr = r_hit_addr;
                    end
                end
                mlt_pkg::OP_STATIC, mlt_pkg::OP_CHADDR: begin
                    o_wdata.info.local_f = 1'b1;
                    if (!bad_addr && r_free && !limit_hit) begin
                        o_we = 1'b1; o_waddr = r_free_addr;
                    end
                end
                default: o_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_idx <= '0; r_rd_vld <= 1'b0; r_time <= '0;
            r_count <= '0; r_removed <= '0; r_hit <= 1'b0; r_free <= 1'b0;
            r_cl <= 1'b0; r_ov <= 1'b0; r_status <= '0; r_dest <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0; r_rd_vld <= 1'b0; r_removed <= '0;
                    r_hit <= 1'b0; r_free <= 1'b0; r_cl <= 1'b0;
                    if (i_in_valid) begin
                        r_op <= i_opcode; r_mac <= i_mac_address; r_dev <= i_phys_device;
                        r_port <= i_port_id; r_all <= i_all_ports; r_mode <= i_local_mode;
                        if (i_opcode == mlt_pkg::OP_TICK) begin
                            r_time <= r_time + 32'd1;
                            r_ov <= 1'b1; r_status <= mlt_pkg::ST_DONE; r_dest <= '0;
                        end else begin
                            r_idx <= CW'(1); r_rd_vld <= 1'b1;
                        end
                    end
                    r_rd_addr <= '0;
                end
                S_SCAN: begin
                    r_rd_addr <= r_idx[AW-1:0];
                    r_rd_vld  <= (r_idx != CW'(TABLE_ENTRIES));
                    if (r_idx != CW'(TABLE_ENTRIES)) r_idx <= r_idx + 1'b1;
                    if (r_rd_vld) begin
                        if (key_m && !r_hit) begin
                            r_hit <= 1'b1; r_hit_addr <= r_rd_addr; r_hit_info <= s.info;
                        end
                        if ((!s.info.valid || del_m) && !r_free) begin
                            r_free <= 1'b1; r_free_addr <= r_rd_addr;
                        end
                        if (r_op == mlt_pkg::OP_CHADDR && cl_m && !r_cl) begin
                            r_cl <= 1'b1;
                        end
                        if (del_m) begin
                            r_count <= r_count - 1'b1; r_removed <= r_removed + 9'd1;
                        end
                    end
                end
                S_FIN: begin
                    r_ov <= 1'b1; r_dest <= '0; r_status <= mlt_pkg::ST_DONE;
                    unique case (r_op) inside
                        mlt_pkg::OP_LEARN: begin
                            if (!r_hit) begin
                                if (r_free && !limit_hit) begin
                                    r_status <= mlt_pkg::ST_CREATED; r_count <= r_count + 1'b1;
                                end else r_status <= mlt_pkg::ST_FULL;
                            end
                        end
                        mlt_pkg::OP_LOOKUP: begin
                            if (r_hit) r_dest <= r_hit_info.port;
                            else r_status <= mlt_pkg::ST_MISS;
                        end
                        mlt_pkg::OP_STATIC, mlt_pkg::OP_CHADDR: begin
                            if (bad_addr) begin
                                r_status <= mlt_pkg::ST_INVALID;
                            end else if (r_free && !limit_hit) begin
                                r_status <= mlt_pkg::ST_CREATED; r_count <= r_count + 1'b1;
                            end else begin
                                r_status <= mlt_pkg::ST_FULL;
                            end
                        end
                        default: r_status <= mlt_pkg::ST_DONE;
                    endcase
                end
                S_OUT: if (!i_out_stall) r_ov <= 1'b0;
                default: r_ov <= 1'b0;
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_status;
    assign o_dest_port     = r_dest;
    assign o_removed_count = r_removed;
    assign o_live_count    = 9'(r_count);

    `MLT_ASSERT_IMPL(a_ov_out, i_clk, i_rst_n, r_ov, r_state == S_OUT, "result outside output state")
    `MLT_ASSERT_IMPL(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_ENTRIES), "count overflow")
    `MLT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && i_out_stall, $stable(r_status) && r_ov,
        "stalled result changed")
    `MLT_ASSERT_IMPL(a_we_busy, i_clk, i_rst_n, o_we, r_state == S_SCAN || r_state == S_FIN,
        "write while idle")
endmodule

// ----- hw/rtl/mac_learning_forwarding_table.sv -----
// ----------------------------------------------------------------------------
// mac_learning_forwarding_table
// MAC learning table with ageing: slot memories, scan sequencer, registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_stall   | opcode, mac, device, port, flags
//  out     | output    | o_out_valid/i_out_stall | status, dest port, counts
//  cfg     | input     | APB psel/penable/pwrite | max_entries, ageing_ticks
// Every operation but tick reads all TABLE_ENTRIES slots from the slot memory
// read port, one a cycle; a tick skips the scan and goes straight to its result.
// The scan of one item finishes before the next item is taken.
// Reset is synchronous; valid bits lie in flops, so no clearing pass runs.
// A stalled result holds the block until it is taken.
module mac_learning_forwarding_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [47:0] i_mac_address,
    input  logic [3:0]  i_phys_device,
    input  logic [5:0]  i_port_id,
    input  logic        i_all_ports,
    input  logic [1:0]  i_local_mode,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_dest_port,
    output logic [8:0]  o_removed_count,
    output logic [8:0]  o_live_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [8:0]  r_max_entries;
    logic [15:0] r_ageing_ticks;
    logic [AW-1:0] raddr, waddr;
    logic we;
    mlt_pkg::t_slot rdata, wdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries  <= 9'd256;
            r_ageing_ticks <= 16'd300;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == mlt_pkg::REG_MAX_ENTRIES[0]) r_max_entries <= pwdata[8:0];
            else r_ageing_ticks <= pwdata[15:0];
        end
    end

    always_comb begin
        case (paddr[2])
            mlt_pkg::REG_AGEING_TICKS[0]: prdata = {16'd0, r_ageing_ticks};
            default:                      prdata = {23'd0, r_max_entries};
        endcase
    end

    mlt_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(raddr), .o_rdata(rdata),
        .i_we(we), .i_waddr(waddr), .i_wdata(wdata)
    );

    mlt_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_mac_address(i_mac_address),
        .i_phys_device(i_phys_device), .i_port_id(i_port_id),
        .i_all_ports(i_all_ports), .i_local_mode(i_local_mode),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_dest_port(o_dest_port),
        .o_removed_count(o_removed_count), .o_live_count(o_live_count),
        .i_max_entries(r_max_entries), .i_ageing_ticks(r_ageing_ticks),
        .o_raddr(raddr), .i_rdata(rdata), .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives table operations into the MAC learning table and checks every result
// against a behavioral copy of the table kept in the testbench. Covers
// directed cases, a full-capacity fill and random traffic with handshake
// idling on both sides and several register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS      = 256;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 300;

    typedef struct {
        logic [2:0]  op;
        logic [47:0] mac;
        logic [3:0]  dev;
        logic [5:0]  port;
        logic        all;
        logic [1:0]  mode;
    } t_op;

    typedef struct {
        logic [2:0] status;
        logic [5:0] dest;
        logic [8:0] removed;
        logic [8:0] live;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall;
    logic [2:0]  i_opcode;
    logic [47:0] i_mac_address;
    logic [3:0]  i_phys_device;
    logic [5:0]  i_port_id;
    logic        i_all_ports;
    logic [1:0]  i_local_mode;
    logic        o_out_valid, i_out_stall;
    logic [2:0]  o_status;
    logic [5:0]  o_dest_port;
    logic [8:0]  o_removed_count, o_live_count;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    mac_learning_forwarding_table uut (.*);

    // table copy
    logic [47:0] fdb_mac    [SLOTS];
    logic        fdb_valid  [SLOTS];
    logic        fdb_local  [SLOTS];
    logic [5:0]  fdb_port   [SLOTS];
    logic [3:0]  fdb_dev    [SLOTS];
    logic [31:0] fdb_expiry [SLOTS];
    logic [31:0] fdb_now;
    int          fdb_live;
    logic [8:0]  cfg_max_entries;
    logic [15:0] cfg_ageing;

    t_res        pending_results[$];
    int          mismatches, results_seen, ops_sent;
    int          op_hist[8];
    int          src_idle_pct, dst_idle_pct;
    longint      cycles;
    logic [47:0] mac_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------- predictor ----------------
    function automatic int fdb_find(logic [47:0] mac, logic [3:0] dev);
        for (int i = 0; i < SLOTS; i++)
            if (fdb_valid[i] && fdb_mac[i] == mac && fdb_dev[i] == dev) return i;
        return -1;
    endfunction

    function automatic void fdb_drop(int i, ref int removed);
        fdb_valid[i] = 1'b0;
        fdb_live--;
        removed++;
    endfunction

    function automatic bit fdb_create(logic [47:0] mac, logic [3:0] dev, logic [5:0] port,
                                      logic loc);
        if (cfg_max_entries != 0 && fdb_live >= cfg_max_entries) return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!fdb_valid[i]) begin
                fdb_mac[i]    = mac;
                fdb_valid[i]  = 1'b1;
                fdb_local[i]  = loc;
                fdb_port[i]   = port;
                fdb_dev[i]    = dev;
                fdb_expiry[i] = fdb_now + 32'(cfg_ageing);
                fdb_live++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] fdb_static(t_op x, ref int removed);
        int i;
        if (x.mac == 48'd0 || x.mac[40]) return mlt_pkg::ST_INVALID;
        i = fdb_find(x.mac, x.dev);
        if (i >= 0) fdb_drop(i, removed);
        return fdb_create(x.mac, x.dev, x.port, 1'b1) ? mlt_pkg::ST_CREATED
                                                      : mlt_pkg::ST_FULL;
    endfunction

    function automatic t_res fdb_apply(t_op x);
        t_res r;
        int   i;
        int   removed;
        logic [31:0] age;
        removed = 0;
        r.status = mlt_pkg::ST_DONE;
        r.dest = '0;
        case (x.op)
            mlt_pkg::OP_LEARN: begin
                i = fdb_find(x.mac, x.dev);
                if (i >= 0) begin
                    fdb_port[i] = x.port;
                    fdb_expiry[i] = fdb_now + 32'(cfg_ageing);
                end else begin
                    r.status = fdb_create(x.mac, x.dev, x.port, 1'b0) ? mlt_pkg::ST_CREATED
                                                                      : mlt_pkg::ST_FULL;
                end
            end
            mlt_pkg::OP_STATIC: r.status = fdb_static(x, removed);
            mlt_pkg::OP_LOOKUP: begin
                i = fdb_find(x.mac, x.dev);
                if (i >= 0) begin
                    if (!fdb_local[i]) fdb_expiry[i] = fdb_now + 32'(cfg_ageing);
                    r.dest = fdb_port[i];
                end else begin
                    r.status = mlt_pkg::ST_MISS;
                end
            end
            mlt_pkg::OP_CHADDR: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (fdb_valid[i] && fdb_local[i] && fdb_port[i] == x.port) begin
                        fdb_drop(i, removed);
                        break;
                    end
                end
                r.status = fdb_static(x, removed);
            end
            mlt_pkg::OP_DELPRT: begin
                for (i = 0; i < SLOTS; i++)
                    if (fdb_valid[i] && (x.all || fdb_port[i] == x.port)) fdb_drop(i, removed);
            end
            mlt_pkg::OP_DELDEV: begin
                for (i = 0; i < SLOTS; i++)
                    if (fdb_valid[i] && fdb_dev[i] == x.dev &&
                        ({1'b0, fdb_local[i]} == x.mode || x.mode == mlt_pkg::MODE_BOTH))
                        fdb_drop(i, removed);
            end
            mlt_pkg::OP_SWEEP: begin
                for (i = 0; i < SLOTS; i++) begin
                    age = fdb_now - fdb_expiry[i];
                    if (fdb_valid[i] && !fdb_local[i] && !age[31]) fdb_drop(i, removed);
                end
            end
            default: fdb_now = fdb_now + 32'd1;
        endcase
        r.removed = 9'(removed);
        r.live = 9'(fdb_live);
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_dest_port !== want.dest ||
                    o_removed_count !== want.removed || o_live_count !== want.live) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch cycle %0d: status %0d/%0d port %0d/%0d ",
                                  "removed %0d/%0d live %0d/%0d (exp/got)"},
                                 cycles, want.status, o_status, want.dest, o_dest_port,
                                 want.removed, o_removed_count, want.live, o_live_count);
                end
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    // ---------------- drivers ----------------
    task automatic send_op(t_op x);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = x.op; i_mac_address = x.mac; i_phys_device = x.dev;
        i_port_id = x.port; i_all_ports = x.all; i_local_mode = x.mode;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(fdb_apply(x));
        op_hist[x.op]++;
        ops_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_fields(logic [2:0] op, logic [47:0] mac, logic [3:0] dev,
                               logic [5:0] port, logic all = 1'b0, logic [1:0] mode = 2'd0);
        t_op x;
        x.op = op; x.mac = mac; x.dev = dev; x.port = port; x.all = all; x.mode = mode;
        send_op(x);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        wait_idle();
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 3'(idx * 4); pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == mlt_pkg::REG_MAX_ENTRIES) cfg_max_entries = value[8:0];
        else cfg_ageing = value[15:0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // ---------------- tests ----------------
    task automatic test_learn_lookup();
        send_fields(mlt_pkg::OP_LOOKUP, 48'h0000_0000_0001, 4'd0, 6'd0);
        send_fields(mlt_pkg::OP_LEARN, 48'hFFFF_FFFF_FFFF, 4'hF, 6'h3F);
        send_fields(mlt_pkg::OP_LEARN, 48'd0, 4'd0, 6'd0);
        send_fields(mlt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'hF, 6'h0);
        send_fields(mlt_pkg::OP_LEARN, 48'hFFFF_FFFF_FFFF, 4'hF, 6'h15);
        send_fields(mlt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'hF, 6'h0);
        send_fields(mlt_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'hE, 6'h0);
    endtask

    task automatic test_static_insert();
        send_fields(mlt_pkg::OP_STATIC, 48'd0, 4'd1, 6'd1);
        send_fields(mlt_pkg::OP_STATIC, 48'h0100_0000_0000, 4'd1, 6'd1);
        send_fields(mlt_pkg::OP_STATIC, 48'h0200_0000_0001, 4'd1, 6'd7);
        send_fields(mlt_pkg::OP_STATIC, 48'h0200_0000_0001, 4'd1, 6'd9);
        send_fields(mlt_pkg::OP_LEARN, 48'h0200_0000_0001, 4'd1, 6'd7);
        send_fields(mlt_pkg::OP_CHADDR, 48'h0200_0000_0002, 4'd2, 6'd7);
        send_fields(mlt_pkg::OP_CHADDR, 48'h0300_0000_0000, 4'd2, 6'd8);
    endtask

    task automatic test_delete_and_age();
        send_fields(mlt_pkg::OP_TICK, 48'd0, 4'd0, 6'd0);
        send_fields(mlt_pkg::OP_SWEEP, 48'd0, 4'd0, 6'd0);
        send_fields(mlt_pkg::OP_DELDEV, 48'd0, 4'd2, 6'd0, 1'b0, 2'd3);
        send_fields(mlt_pkg::OP_DELDEV, 48'd0, 4'd2, 6'd0, 1'b0, 2'd1);
        send_fields(mlt_pkg::OP_DELDEV, 48'd0, 4'hF, 6'd0, 1'b0, 2'd0);
        send_fields(mlt_pkg::OP_LEARN, 48'h0A00_0000_0005, 4'd3, 6'd4);
        send_fields(mlt_pkg::OP_DELDEV, 48'd0, 4'd3, 6'd0, 1'b0, mlt_pkg::MODE_BOTH);
        send_fields(mlt_pkg::OP_DELPRT, 48'd0, 4'd0, 6'd9);
        send_fields(mlt_pkg::OP_DELPRT, 48'd0, 4'd0, 6'd0, 1'b1);
    endtask

    // limit reached, then ageing with an ageing setting of 1
    task automatic test_limits();
        write_reg(mlt_pkg::REG_MAX_ENTRIES, 32'd2);
        write_reg(mlt_pkg::REG_AGEING_TICKS, 32'd1);
        for (int i = 0; i < 3; i++)
            send_fields(mlt_pkg::OP_LEARN, 48'h0C00_0000_0010 + 48'(i), 4'd0, 6'd2);
        send_fields(mlt_pkg::OP_STATIC, 48'h0C00_0000_0020, 4'd0, 6'd2);
        send_fields(mlt_pkg::OP_TICK, 48'd0, 4'd0, 6'd0);
        send_fields(mlt_pkg::OP_SWEEP, 48'd0, 4'd0, 6'd0);
        // fill the whole table with no limit
        write_reg(mlt_pkg::REG_MAX_ENTRIES, 32'd0);
        write_reg(mlt_pkg::REG_AGEING_TICKS, 32'd65535);
        for (int i = 0; i <= SLOTS; i++)
            send_fields(mlt_pkg::OP_LEARN, 48'h0E00_0000_0000 + 48'(i), 4'(i), 6'(i));
        send_fields(mlt_pkg::OP_DELPRT, 48'd0, 4'd0, 6'd0, 1'b1);
    endtask

    function automatic t_op random_op();
        t_op x;
        int  w;
        w = $urandom_range(99);
        x.op = w < 30 ? mlt_pkg::OP_LEARN : w < 55 ? mlt_pkg::OP_LOOKUP :
               w < 65 ? mlt_pkg::OP_STATIC : w < 72 ? mlt_pkg::OP_CHADDR :
               w < 76 ? mlt_pkg::OP_DELPRT : w < 80 ? mlt_pkg::OP_DELDEV :
               w < 88 ? mlt_pkg::OP_SWEEP : mlt_pkg::OP_TICK;
        x.mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                         : mac_pool[$urandom_range(7)];
        x.dev = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        x.port = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(3));
        x.all = ($urandom_range(5) == 0);
        x.mode = 2'($urandom);
        return x;
    endfunction

    task automatic test_random(int count, int src_pct, int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        repeat (count) send_op(random_op());
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0;
        i_opcode = '0; i_mac_address = '0; i_phys_device = '0;
        i_port_id = '0; i_all_ports = 1'b0; i_local_mode = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; results_seen = 0; ops_sent = 0;
        src_idle_pct = 0; dst_idle_pct = 0;
        foreach (op_hist[i]) op_hist[i] = 0;
        foreach (fdb_valid[i]) fdb_valid[i] = 1'b0;
        fdb_now = '0; fdb_live = 0;
        cfg_max_entries = 9'd256; cfg_ageing = 16'd300;
        foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom}) & ~48'h0100_0000_0000;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_learn_lookup();
        test_static_insert();
        test_delete_and_age();
        test_limits();

        write_reg(mlt_pkg::REG_MAX_ENTRIES, 32'd256);
        write_reg(mlt_pkg::REG_AGEING_TICKS, 32'd4);
        test_random(55, 32, 67);
        write_reg(mlt_pkg::REG_MAX_ENTRIES, 32'd6);
        write_reg(mlt_pkg::REG_AGEING_TICKS, 32'd2);
        test_random(55, 67, 32);
        write_reg(mlt_pkg::REG_MAX_ENTRIES, 32'd0);
        write_reg(mlt_pkg::REG_AGEING_TICKS, 32'd9);
        test_random(55, 0, 0);

        wait_idle();
        $display("Sent %0d operations, checked %0d results",
                 ops_sent, results_seen);
        $display("Per opcode: %0d %0d %0d %0d %0d %0d %0d %0d",
                 op_hist[0], op_hist[1], op_hist[2], op_hist[3],
                 op_hist[4], op_hist[5], op_hist[6], op_hist[7]);
        $display("Register settings included limits 256, 2, 6 and none; mismatches: %0d",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
